>>> hdl/htld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree load and decode - shared types and constants
// Transaction payloads, opcodes, tree characters and node table entry layout.
// ----------------------------------------------------------------------------
package htld_pkg;

    // Input opcodes
    localparam logic [1:0] OP_TREE  = 2'd0;
    localparam logic [1:0] OP_CODE  = 2'd1;
    localparam logic [1:0] OP_FINAL = 2'd2;

    // Tree serialization characters
    localparam logic [7:0] CH_ESCAPE = 8'h24;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;

    // Bits in one code byte
    localparam int unsigned BYTE_BITS = 8;

    // A link: bit 8 marks a leaf, bits 7..0 hold the symbol or the node index.
    localparam int unsigned LINK_W   = 9;
    localparam int unsigned LEAF_BIT = 8;
    // A node table entry: left-filled flag, right link, left link.
    localparam int unsigned ENTRY_W  = 2 * LINK_W + 1;

    typedef logic [LINK_W-1:0]  t_link;
    typedef logic [ENTRY_W-1:0] t_entry;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_of_run;
    } t_out_item;

endpackage

>>> hdl/huffman_tree_load_and_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman tree load and decode
// Builds a code tree from a parenthesized preorder stream, then decodes code
// bytes against it, one symbol per leaf reached.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one opcode and
//   one byte per transaction. Tree bytes (OP_TREE) load the tree; code bytes
//   (OP_CODE, OP_FINAL) are decoded MSB first. Output channel (o_out_valid /
//   i_out_stall / o_out_data) carries one decoded symbol per transaction, with
//   last_of_run set on the last symbol from one code byte.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes pad_bits,
//   the padding bits dropped from the low end of a final code byte. Write it
//   only while the block is idle; ready is always high.
// Timing:
//   An attaching tree byte (leaf, escaped byte, open) does a read-modify-write
//   of the node table, read in S_IDLE and written in S_ATTACH; a close pops the
//   parent stack in S_POP. A code byte is accepted, walked one code bit per
//   S_WALK step, and its held symbol flushed in S_FLUSH. The per-bit loop is
//   bound by the registered node table read: each read address comes from the
//   previous data. A symbol is valid the cycle after the next leaf or flush.
// Reset and stall:
//   Reset empties the tree (stack holds only the root) and sets pad_bits to 0;
//   no memory clearing pass is needed. A stalled output holds its symbol and
//   the walk pauses where it must push a held symbol, keeping its place in the byte.
// ----------------------------------------------------------------------------
module huffman_tree_load_and_decode #(
    parameter int unsigned NODE_COUNT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input item channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  htld_pkg::t_in_item   i_in_data,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output htld_pkg::t_out_item  o_out_data,
    // Configuration write channel: pad_bits
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_data
);
    import htld_pkg::*;

    // Node index and counter widths follow the table depth.
    localparam int unsigned NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int unsigned CW = $clog2(NODE_COUNT + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(NODE_COUNT);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_TWO  = CW'(2);
    localparam logic [NW-1:0] ROOT     = '0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ATTACH,
        S_POP,
        S_WALK,
        S_FLUSH
    } t_state;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state           r_state,        n_state;
    logic [2:0]       r_pad,          n_pad;
    logic             r_escape,       n_escape;
    logic [CW-1:0]    r_stack_cnt,    n_stack_cnt;
    logic [CW-1:0]    r_next_free,    n_next_free;
    logic [NW-1:0]    r_top,          n_top;
    logic             r_pop_root,     n_pop_root;
    logic             r_root_init,    n_root_init;
    logic [NW-1:0]    r_attach_node,  n_attach_node;
    t_link            r_link,         n_link;
    logic [NW-1:0]    r_walk,         n_walk;
    logic [7:0]       r_bits,         n_bits;
    logic [3:0]       r_bits_left,    n_bits_left;
    logic             r_final,        n_final;
    logic             r_pend_valid,   n_pend_valid;
    logic [7:0]       r_pend_sym,     n_pend_sym;
    logic             r_out_valid,    n_out_valid;
    t_out_item        r_out,          n_out;

    // Node table: left-filled flag and two links per node.
    t_entry           r_links [NODE_COUNT];
    t_entry           r_rdata;
    logic             mem_we;
    logic [NW-1:0]    mem_waddr;
    t_entry           mem_wdata;
    logic [NW-1:0]    mem_raddr;

    // Parent stack; entry zero is the root and is never stored.
    logic [NW-1:0]    r_stack [NODE_COUNT];
    logic [NW-1:0]    r_stack_rdata;
    logic             stk_we;
    logic [NW-1:0]    stk_waddr;
    logic [NW-1:0]    stk_wdata;
    logic [NW-1:0]    stk_raddr;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Walk step: r_rdata holds the entry of r_walk
    // ------------------------------------------------------------------
    t_link         walk_link;
    logic          walk_leaf;
    logic          walk_ok;
    logic [NW-1:0] walk_next;

    assign walk_link = r_bits[7] ? r_rdata[2*LINK_W-1:LINK_W] : r_rdata[LINK_W-1:0];
    assign walk_leaf = walk_link[LEAF_BIT];
    // A second leaf pushes the held symbol out, so it needs a free output slot.
    assign walk_ok   = !(walk_leaf && r_pend_valid) || out_free;
    assign walk_next = walk_leaf ? ROOT : walk_link[NW-1:0];

    // Entry as seen by an attach; the root reads empty until first written.
    t_entry attach_entry;
    logic   attach_raw;

    assign attach_raw   = (r_attach_node == ROOT) && !r_root_init;
    assign attach_entry = attach_raw ? '0 : r_rdata;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    logic          do_attach;
    t_link         attach_link;
    logic          push;
    t_out_item     push_item;
    logic [NW-1:0] fresh;

    assign fresh = r_next_free[NW-1:0];

    always_comb begin
        n_state       = r_state;
        n_pad         = r_pad;
        n_escape      = r_escape;
        n_stack_cnt   = r_stack_cnt;
        n_next_free   = r_next_free;
        n_top         = r_top;
        n_pop_root    = r_pop_root;
        n_root_init   = r_root_init;
        n_attach_node = r_attach_node;
        n_link        = r_link;
        n_walk        = r_walk;
        n_bits        = r_bits;
        n_bits_left   = r_bits_left;
        n_final       = r_final;
        n_pend_valid  = r_pend_valid;
        n_pend_sym    = r_pend_sym;
        n_out_valid   = r_out_valid;
        n_out         = r_out;

        mem_we        = 1'b0;
        mem_waddr     = r_attach_node;
        mem_wdata     = '0;
        mem_raddr     = r_walk;
        stk_we        = 1'b0;
        stk_waddr     = r_stack_cnt[NW-1:0];
        stk_wdata     = fresh;
        stk_raddr     = r_stack_cnt[NW-1:0];

        do_attach     = 1'b0;
        attach_link   = '0;
        push          = 1'b0;
        push_item     = '0;

        if (i_cfg_valid) begin
            n_pad = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.opcode)
                        OP_TREE: begin
                            if (r_escape) begin
                                n_escape    = 1'b0;
                                do_attach   = 1'b1;
                                attach_link = {1'b1, i_in_data.byte_value};
                            end else begin
                                case (i_in_data.byte_value)
                                    CH_ESCAPE: begin
                                        n_escape = 1'b1;
                                    end
                                    CH_OPEN: begin
                                        // Drop the open when the table or stack is full.
                                        if (r_next_free < CNT_FULL
                                                && r_stack_cnt < CNT_FULL) begin
                                            mem_we      = 1'b1;
                                            mem_waddr   = fresh;
                                            mem_wdata   = '0;
                                            do_attach   = 1'b1;
                                            attach_link = {1'b0, 8'(fresh)};
                                            stk_we      = 1'b1;
                                            n_top       = fresh;
                                            n_stack_cnt = r_stack_cnt + CNT_ONE;
                                            n_next_free = r_next_free + CNT_ONE;
                                        end
                                    end
                                    CH_CLOSE: begin
                                        // Drop the close when only the root is open.
                                        if (r_stack_cnt > CNT_ONE) begin
                                            n_stack_cnt = r_stack_cnt - CNT_ONE;
                                            stk_raddr   = NW'(r_stack_cnt - CNT_TWO);
                                            n_pop_root  = (r_stack_cnt == CNT_TWO);
                                            n_state     = S_POP;
                                        end
                                    end
                                    default: begin
                                        do_attach   = 1'b1;
                                        attach_link = {1'b1, i_in_data.byte_value};
                                    end
                                endcase
                            end
                        end
                        OP_CODE, OP_FINAL: begin
                            n_bits      = i_in_data.byte_value;
                            n_final     = (i_in_data.opcode == OP_FINAL);
                            n_bits_left = (i_in_data.opcode == OP_FINAL)
                                        ? 4'(BYTE_BITS) - {1'b0, r_pad}
                                        : 4'(BYTE_BITS);
                            n_state     = S_WALK;
                        end
                        default: begin
                        end
                    endcase

                    if (do_attach) begin
                        n_link        = attach_link;
                        n_attach_node = r_top;
                        mem_raddr     = r_top;
                        n_state       = S_ATTACH;
                    end
                end
            end

            S_ATTACH: begin
                // Fill left then right; a third child wraps to the left again.
                mem_we    = 1'b1;
                mem_waddr = r_attach_node;
                if (attach_entry[ENTRY_W-1]) begin
                    mem_wdata = {1'b0, r_link, attach_entry[LINK_W-1:0]};
                end else begin
                    mem_wdata = {1'b1, attach_entry[2*LINK_W-1:LINK_W], r_link};
                end
                if (r_attach_node == ROOT) begin
                    n_root_init = 1'b1;
                end
                n_state = S_IDLE;
            end

            S_POP: begin
                n_top   = r_pop_root ? ROOT : r_stack_rdata;
                n_state = S_IDLE;
            end

            S_WALK: begin
                if (walk_ok) begin
                    n_bits      = {r_bits[6:0], 1'b0};
                    n_bits_left = r_bits_left - 4'd1;
                    n_walk      = walk_next;
                    mem_raddr   = walk_next;
                    if (walk_leaf) begin
                        // Hold the new symbol until it is known whether it ends the run.
                        n_pend_valid = 1'b1;
                        n_pend_sym   = walk_link[7:0];
                        if (r_pend_valid) begin
                            push      = 1'b1;
                            push_item = '{symbol: r_pend_sym, last_of_run: 1'b0};
                        end
                    end
                    if (r_bits_left == 4'd1) begin
                        n_state = S_FLUSH;
                    end
                end
            end

            S_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        push         = 1'b1;
                        push_item    = '{symbol: r_pend_sym, last_of_run: 1'b1};
                        n_pend_valid = 1'b0;
                    end
                    if (r_final) begin
                        n_walk = ROOT;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Output register
        if (push) begin
            n_out_valid = 1'b1;
            n_out       = push_item;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // State and output registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pad        <= '0;
            r_escape     <= 1'b0;
            r_stack_cnt  <= CNT_ONE;
            r_next_free  <= CNT_ONE;
            r_top        <= ROOT;
            r_root_init  <= 1'b0;
            r_walk       <= ROOT;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pad        <= n_pad;
            r_escape     <= n_escape;
            r_stack_cnt  <= n_stack_cnt;
            r_next_free  <= n_next_free;
            r_top        <= n_top;
            r_root_init  <= n_root_init;
            r_walk       <= n_walk;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_pop_root    <= n_pop_root;
        r_attach_node <= n_attach_node;
        r_link        <= n_link;
        r_bits        <= n_bits;
        r_bits_left   <= n_bits_left;
        r_final       <= n_final;
        r_pend_sym    <= n_pend_sym;
        r_out         <= n_out;
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_links[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_links[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_waddr] <= stk_wdata;
        end
        r_stack_rdata <= r_stack[stk_raddr];
    end

endmodule
